[design/ebp_pkg.sv]
// Shared types and constants of the embedding bag pooler.
// Used by ebp_divider, ebp_isqrt and embedding_bag_pooler; depends on nothing.
package ebp_pkg;

   // Input commands.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   // Register indexes (byte address is 4 times the index).
   localparam logic [2:0] REG_DIM_IN_USE   = 3'd0;
   localparam logic [2:0] REG_VOCAB_IN_USE = 3'd1;
   localparam logic [2:0] REG_UNKNOWN_ID   = 3'd2;
   localparam logic [2:0] REG_DROP_UNKNOWN = 3'd3;
   localparam logic [2:0] REG_EMPTY_RAISE  = 3'd4;
   localparam logic [2:0] REG_NORMALIZE_L2 = 3'd5;

   localparam logic [5:0]  RESET_DIM_IN_USE   = 6'd32;
   localparam logic [12:0] RESET_VOCAB_IN_USE = 13'd4096;

   // Widths of the arithmetic units.
   localparam int DIV_NUM_W  = 41;
   localparam int DIV_DEN_W  = 32;
   localparam int SQRT_W     = 64;
   localparam int ROOT_W     = 32;
   localparam int VOCAB_CMP_W = 17;

   typedef struct packed {
      logic [1:0]         command;
      logic [15:0]        token_id;
      logic [11:0]        table_row;
      logic [4:0]         table_column;
      logic signed [15:0] entry_value;
   } ebp_req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         element_index;
      logic signed [15:0] element_value;
      logic [15:0]        token_count;
      logic [15:0]        unknown_count;
      logic               last;
   } ebp_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic              start;
      logic [SQRT_W-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_rsp_type;

endpackage

[design/embedding_bag_pooler.sv]
// Embedding bag pooler: table memory, accumulator memory and the bag sequencer.
// Depends on ebp_pkg, ebp_divider and ebp_isqrt.
//
// Usage: req_ words carry write, add and end commands; rsp_ words carry one
// pooled element each, the final one of a bag flagged by last. The csr_ port
// sets the row width, vocabulary, unknown id and pooling mode; the user must
// write it only while idle, as the block itself does not enforce this. In
// an add that sums a row, the sequencer walks the single-element ports of the
// table and accumulator memories, reading one element and writing the sum
// back in the following cycle. With d the row width in use, an end word gives
// d results (one for an error or a raised empty bag). The mean divides each
// element in the shared radix-2 divider. The L2 mode adds a max pass,
// normalizing shifts, a square-sum pass and a root extraction before a
// divide per element.
// Reset clears the bag and the registers; the table holds whatever was last
// written and needs no clearing pass. A stalled receiver holds the output
// register; the sequencer waits for it, and once the final result is parked,
// input words are taken again even while the receiver still stalls.
module embedding_bag_pooler #(
   parameter int DIM   = 32,
   parameter int VOCAB = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ebp_pkg::ebp_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ebp_pkg::ebp_rsp_type rsp_word,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [4:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   localparam int AW  = $clog2(DIM * VOCAB);
   localparam int JW  = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int JW1 = $clog2(DIM + 1);
   localparam int VW  = ebp_pkg::VOCAB_CMP_W;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_ADD        = 4'd1;
   localparam logic [3:0] S_LMAX_RD    = 4'd2;
   localparam logic [3:0] S_LMAX_DAT   = 4'd3;
   localparam logic [3:0] S_LNORM      = 4'd4;
   localparam logic [3:0] S_LSQ_RD     = 4'd5;
   localparam logic [3:0] S_LSQ_DAT    = 4'd6;
   localparam logic [3:0] S_LSQ_MUL    = 4'd7;
   localparam logic [3:0] S_LSQ_ADD    = 4'd8;
   localparam logic [3:0] S_LSQRT      = 4'd9;
   localparam logic [3:0] S_ERD        = 4'd10;
   localparam logic [3:0] S_EDAT       = 4'd11;
   localparam logic [3:0] S_LDIV_START = 4'd12;
   localparam logic [3:0] S_DIV        = 4'd13;
   localparam logic [3:0] S_PUSH       = 4'd14;

   localparam logic [1:0] MODE_SINGLE = 2'd0;
   localparam logic [1:0] MODE_ZERO   = 2'd1;
   localparam logic [1:0] MODE_MEAN   = 2'd2;
   localparam logic [1:0] MODE_L2     = 2'd3;

   // Configuration registers.
   logic [5:0]  dim_in_use_ff;
   logic [12:0] vocab_in_use_ff;
   logic [11:0] unknown_id_ff;
   logic        drop_unknown_ff, empty_raise_ff, normalize_l2_ff;

   // Sequencer and bag state.
   logic [3:0]         state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic [JW1-1:0]     j_ff, j_in;
   logic               pipe_v_ff, pipe_v_in;
   logic [JW-1:0]      pipe_j_ff, pipe_j_in;
   logic [15:0]        id_ff, id_in;
   logic [15:0]        used_count_ff, used_count_in;
   logic [15:0]        seen_count_ff, seen_count_in;
   logic [15:0]        unknown_seen_ff, unknown_seen_in;
   logic               range_error_ff, range_error_in;
   logic [1:0]         status_ff, status_in;
   logic signed [15:0] val_ff, val_in;
   logic               neg_ff, neg_in;
   logic [31:0]        max_ff, max_in;
   logic signed [5:0]  sh_ff, sh_in;
   logic [26:0]        m_ff, m_in;
   logic [53:0]        sq_ff, sq_in;
   logic [63:0]        sum_ff, sum_in;
   logic [31:0]        root_ff, root_in;
   logic               clear_bag;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   ebp_pkg::ebp_rsp_type rsp_word_ff, rsp_word_in;
   logic                 push;
   ebp_pkg::ebp_rsp_type push_word;
   logic                 can_push;

   // Memories.
   logic signed [15:0] tbl_mem [DIM * VOCAB];
   logic signed [15:0] tbl_rd_ff;
   logic               tbl_we;
   logic [AW-1:0]      tbl_waddr, tbl_raddr;
   logic signed [31:0] acc_mem [DIM];
   logic [DIM-1:0]     acc_valid_ff;
   logic signed [31:0] acc_rd_ff;
   logic               acc_rdv_ff;
   logic               acc_we;
   logic signed [31:0] acc_wdata;
   logic [JW-1:0]      acc_raddr;

   ebp_pkg::div_req_type  div_req;
   ebp_pkg::div_rsp_type  div_rsp;
   ebp_pkg::sqrt_req_type sqrt_req;
   ebp_pkg::sqrt_rsp_type sqrt_rsp;

   logic               accept;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [JW1-1:0]     d_eff;
   logic [VW-1:0]      vocab_eff;
   logic               is_unk;
   logic               j_last;
   logic signed [31:0] acc_val;
   logic               acc_neg;
   logic [31:0]        acc_mag;
   logic signed [32:0] acc_sum;
   logic [58:0]        shl;
   logic [31:0]        shr;
   logic [5:0]         sh_neg;
   logic [26:0]        scaled_m;
   logic [40:0]        q;

   ebp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   ebp_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .sqrt_req (sqrt_req),
      .sqrt_rsp (sqrt_rsp)
   );

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      case (csr_index)
         ebp_pkg::REG_DIM_IN_USE:   csr_prdata = {26'b0, dim_in_use_ff};
         ebp_pkg::REG_VOCAB_IN_USE: csr_prdata = {19'b0, vocab_in_use_ff};
         ebp_pkg::REG_UNKNOWN_ID:   csr_prdata = {20'b0, unknown_id_ff};
         ebp_pkg::REG_DROP_UNKNOWN: csr_prdata = {31'b0, drop_unknown_ff};
         ebp_pkg::REG_EMPTY_RAISE:  csr_prdata = {31'b0, empty_raise_ff};
         ebp_pkg::REG_NORMALIZE_L2: csr_prdata = {31'b0, normalize_l2_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_in_use_ff   <= ebp_pkg::RESET_DIM_IN_USE;
         vocab_in_use_ff <= ebp_pkg::RESET_VOCAB_IN_USE;
         unknown_id_ff   <= '0;
         drop_unknown_ff <= 1'b0;
         empty_raise_ff  <= 1'b0;
         normalize_l2_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            ebp_pkg::REG_DIM_IN_USE:   dim_in_use_ff   <= csr_pwdata[5:0];
            ebp_pkg::REG_VOCAB_IN_USE: vocab_in_use_ff <= csr_pwdata[12:0];
            ebp_pkg::REG_UNKNOWN_ID:   unknown_id_ff   <= csr_pwdata[11:0];
            ebp_pkg::REG_DROP_UNKNOWN: drop_unknown_ff <= csr_pwdata[0];
            ebp_pkg::REG_EMPTY_RAISE:  empty_raise_ff  <= csr_pwdata[0];
            ebp_pkg::REG_NORMALIZE_L2: normalize_l2_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- effective sizes ----------------
   always_comb begin
      if (dim_in_use_ff == '0) begin
         d_eff = JW1'(1);
      end else if (int'(dim_in_use_ff) > DIM) begin
         d_eff = JW1'(DIM);
      end else begin
         d_eff = JW1'(dim_in_use_ff);
      end
      if (int'(vocab_in_use_ff) < VOCAB) begin
         vocab_eff = VW'(vocab_in_use_ff);
      end else begin
         vocab_eff = VW'(VOCAB);
      end
   end

   assign is_unk = req_word.token_id == {4'b0, unknown_id_ff};
   assign j_last = JW1'(j_ff + 1'b1) == d_eff;

   // ---------------- memories ----------------
   assign tbl_we = accept && req_word.command == ebp_pkg::CMD_WRITE &&
                   int'(req_word.table_row) < VOCAB && int'(req_word.table_column) < DIM;
   assign tbl_waddr = AW'(AW'(req_word.table_row) * AW'(DIM) + AW'(req_word.table_column));
   assign tbl_raddr = AW'(AW'(id_ff) * AW'(DIM) + AW'(j_ff));
   assign acc_raddr = j_ff[JW-1:0];

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[tbl_waddr] <= req_word.entry_value;
      end
      tbl_rd_ff <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[pipe_j_ff] <= acc_wdata;
      end
      acc_rd_ff <= acc_mem[acc_raddr];
   end

   // Entries not written since the bag was cleared read as zero.
   always_ff @(posedge clock) begin
      if (reset || clear_bag) begin
         acc_valid_ff <= '0;
      end else if (acc_we) begin
         acc_valid_ff[pipe_j_ff] <= 1'b1;
      end
      if (reset || clear_bag) begin
         acc_rdv_ff <= 1'b0;
      end else begin
         acc_rdv_ff <= acc_valid_ff[acc_raddr];
      end
   end

   // ---------------- datapath ----------------
   always_comb begin
      acc_val = acc_rdv_ff ? acc_rd_ff : 32'sd0;
      acc_neg = acc_val[31];
      acc_mag = acc_neg ? 32'(-acc_val) : acc_val;
      acc_sum = 33'(acc_val) + 33'(tbl_rd_ff);
      if (acc_sum[32] != acc_sum[31]) begin
         acc_wdata = acc_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
         acc_wdata = acc_sum[31:0];
      end
      // Scaling keeps the largest magnitude in the 27-bit window.
      sh_neg   = 6'(-sh_ff);
      shl      = 59'(acc_mag) << sh_ff[4:0];
      shr      = acc_mag >> sh_neg;
      scaled_m = sh_ff[5] ? shr[26:0] : shl[26:0];
      q        = div_rsp.quotient;
   end

   assign acc_we   = state_ff == S_ADD && pipe_v_ff;
   assign accept   = req_valid && !req_stall;
   assign req_stall = state_ff != S_IDLE;
   assign can_push = !rsp_valid_ff || !rsp_stall;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      j_in            = j_ff;
      pipe_v_in       = 1'b0;
      pipe_j_in       = pipe_j_ff;
      id_in           = id_ff;
      used_count_in   = used_count_ff;
      seen_count_in   = seen_count_ff;
      unknown_seen_in = unknown_seen_ff;
      range_error_in  = range_error_ff;
      status_in       = status_ff;
      val_in          = val_ff;
      neg_in          = neg_ff;
      max_in          = max_ff;
      sh_in           = sh_ff;
      m_in            = m_ff;
      sq_in           = sq_ff;
      sum_in          = sum_ff;
      root_in         = root_ff;
      clear_bag       = 1'b0;
      push            = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = 41'(acc_mag) + 41'(used_count_ff[15:1]);
      div_req.divisor  = 32'(used_count_ff);
      sqrt_req.start   = 1'b0;
      sqrt_req.value   = sum_ff;
      if (mode_ff == MODE_L2) begin
         div_req.dividend = 41'({m_ff, 13'b0}) + 41'(root_ff[31:1]);
         div_req.divisor  = root_ff;
      end

      push_word.status        = status_ff;
      push_word.element_index = 5'(j_ff);
      push_word.element_value = val_ff;
      push_word.token_count   = seen_count_ff;
      push_word.unknown_count = unknown_seen_ff;
      push_word.last          = mode_ff == MODE_SINGLE || j_last;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_word.command)
                  ebp_pkg::CMD_ADD: begin
                     if (seen_count_ff != 16'hFFFF) begin
                        seen_count_in = seen_count_ff + 16'd1;
                     end
                     if (is_unk && unknown_seen_ff != 16'hFFFF) begin
                        unknown_seen_in = unknown_seen_ff + 16'd1;
                     end
                     if (!range_error_ff) begin
                        if ({1'b0, req_word.token_id} >= vocab_eff) begin
                           range_error_in = 1'b1;
                        end else if (!(drop_unknown_ff && is_unk)) begin
                           id_in = req_word.token_id;
                           j_in  = '0;
                           if (used_count_ff != 16'hFFFF) begin
                              used_count_in = used_count_ff + 16'd1;
                           end
                           state_in = S_ADD;
                        end
                     end
                  end
                  ebp_pkg::CMD_END: begin
                     j_in   = '0;
                     val_in = '0;
                     status_in = ebp_pkg::STATUS_OK;
                     if (range_error_ff || (used_count_ff == '0 && empty_raise_ff)) begin
                        mode_in   = MODE_SINGLE;
                        status_in = range_error_ff ? ebp_pkg::STATUS_RANGE
                                                   : ebp_pkg::STATUS_EMPTY;
                        state_in  = S_PUSH;
                     end else if (used_count_ff == '0) begin
                        mode_in  = MODE_ZERO;
                        state_in = S_PUSH;
                     end else if (!normalize_l2_ff) begin
                        mode_in  = MODE_MEAN;
                        state_in = S_ERD;
                     end else begin
                        mode_in  = MODE_L2;
                        max_in   = '0;
                        state_in = S_LMAX_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ADD: begin
            // Read element j while the sum of element j-1 is written back.
            if (j_ff != d_eff) begin
               pipe_v_in = 1'b1;
               pipe_j_in = j_ff[JW-1:0];
               j_in      = JW1'(j_ff + 1'b1);
            end else if (pipe_v_ff) begin
               state_in = S_IDLE;
            end
         end
         S_LMAX_RD: state_in = S_LMAX_DAT;
         S_LMAX_DAT: begin
            if (acc_mag > max_ff) begin
               max_in = acc_mag;
            end
            if (j_last) begin
               sh_in    = '0;
               state_in = S_LNORM;
            end else begin
               j_in     = JW1'(j_ff + 1'b1);
               state_in = S_LMAX_RD;
            end
         end
         S_LNORM: begin
            if (max_ff == '0) begin
               j_in     = '0;
               val_in   = '0;
               mode_in  = MODE_ZERO;
               state_in = S_PUSH;
            end else if (max_ff[31:27] != '0) begin
               max_in = max_ff >> 1;
               sh_in  = sh_ff - 6'sd1;
            end else if (!max_ff[26]) begin
               max_in = max_ff << 1;
               sh_in  = sh_ff + 6'sd1;
            end else begin
               j_in     = '0;
               sum_in   = '0;
               state_in = S_LSQ_RD;
            end
         end
         S_LSQ_RD: state_in = S_LSQ_DAT;
         S_LSQ_DAT: begin
            m_in     = scaled_m;
            state_in = S_LSQ_MUL;
         end
         S_LSQ_MUL: begin
            sq_in    = m_ff * m_ff;
            state_in = S_LSQ_ADD;
         end
         S_LSQ_ADD: begin
            sum_in = sum_ff + 64'(sq_ff);
            if (j_last) begin
               state_in = S_LSQRT;
            end else begin
               j_in     = JW1'(j_ff + 1'b1);
               state_in = S_LSQ_RD;
            end
         end
         S_LSQRT: begin
            if (!sqrt_rsp.busy && !sqrt_rsp.done) begin
               sqrt_req.start = 1'b1;
            end
            if (sqrt_rsp.done) begin
               root_in  = sqrt_rsp.root;
               j_in     = '0;
               state_in = S_ERD;
            end
         end
         S_ERD: state_in = S_EDAT;
         S_EDAT: begin
            neg_in = acc_neg;
            if (mode_ff == MODE_L2) begin
               m_in     = scaled_m;
               state_in = S_LDIV_START;
            end else begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_LDIV_START: begin
            div_req.start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  val_in = (q > 41'd32768) ? 16'sh8000 : 16'(16'd0 - q[15:0]);
               end else begin
                  val_in = (q > 41'd32767) ? 16'sh7FFF : q[15:0];
               end
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (can_push) begin
               push = 1'b1;
               if (push_word.last) begin
                  clear_bag       = 1'b1;
                  used_count_in   = '0;
                  seen_count_in   = '0;
                  unknown_seen_in = '0;
                  range_error_in  = 1'b0;
                  state_in        = S_IDLE;
               end else begin
                  j_in     = JW1'(j_ff + 1'b1);
                  state_in = (mode_ff == MODE_ZERO) ? S_PUSH : S_ERD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = push_word;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         mode_ff         <= MODE_SINGLE;
         j_ff            <= '0;
         pipe_v_ff       <= 1'b0;
         used_count_ff   <= '0;
         seen_count_ff   <= '0;
         unknown_seen_ff <= '0;
         range_error_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         mode_ff         <= mode_in;
         j_ff            <= j_in;
         pipe_v_ff       <= pipe_v_in;
         used_count_ff   <= used_count_in;
         seen_count_ff   <= seen_count_in;
         unknown_seen_ff <= unknown_seen_in;
         range_error_ff  <= range_error_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      pipe_j_ff   <= pipe_j_in;
      id_ff       <= id_in;
      status_ff   <= status_in;
      val_ff      <= val_in;
      neg_ff      <= neg_in;
      max_ff      <= max_in;
      sh_ff       <= sh_in;
      m_ff        <= m_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      root_ff     <= root_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // ---------------- assertions ----------------
   // An error result is always the only, and therefore last, word of its bag.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.status == ebp_pkg::STATUS_OK) || rsp_word_ff.last)
      else $error("error status on a word that is not last");

   // The shared divider is never restarted while a division is running.
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // Parking the last word of a bag leaves the bag state cleared.
   a_bag_clear: assert property (@(posedge clock) disable iff (reset)
      (push && push_word.last) |=>
         (seen_count_ff == '0 && used_count_ff == '0 && !range_error_ff &&
          acc_valid_ff == '0))
      else $error("bag state not cleared after last word");

   // Write-back in an add only happens while that add is being summed.
   a_add_write: assert property (@(posedge clock) disable iff (reset)
      pipe_v_ff |-> $past(state_ff) == S_ADD)
      else $error("accumulator write outside an add");

endmodule

[design/ebp_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ebp_pkg for its request and response types.
module ebp_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ebp_pkg::div_req_type div_req,
   output ebp_pkg::div_rsp_type div_rsp
);
   localparam int NW = ebp_pkg::DIV_NUM_W;
   localparam int DW = ebp_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, num_ff[NW-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         // The quotient bits shift into the dividend register from the bottom.
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         num_in = {num_ff[NW-2:0], ge};
         cnt_in = CW'(cnt_ff + 1'b1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

endmodule

[design/ebp_isqrt.sv]
// Integer square root, digit by digit, one result bit per cycle.
// Depends on ebp_pkg for its request and response types.
module ebp_isqrt (
   input  logic                  clock,
   input  logic                  reset,
   input  ebp_pkg::sqrt_req_type sqrt_req,
   output ebp_pkg::sqrt_rsp_type sqrt_rsp
);
   localparam int SW = ebp_pkg::SQRT_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] s_ff, s_in;
   logic [SW-1:0] res_ff, res_in;
   logic [SW-1:0] bit_ff, bit_in;
   logic [SW-1:0] trial;

   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      s_in    = s_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (sqrt_req.start) begin
         busy_in = 1'b1;
         s_in    = sqrt_req.value;
         res_in  = '0;
         bit_in  = {2'b01, {(SW - 2){1'b0}}};
      end else if (busy_ff) begin
         if (s_ff >= trial) begin
            s_in   = s_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      s_ff   <= s_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign sqrt_rsp.busy = busy_ff;
   assign sqrt_rsp.done = done_ff;
   assign sqrt_rsp.root = res_ff[ebp_pkg::ROOT_W-1:0];

endmodule
